/* rtl/vfd_pkg.sv */
// Shared types, constants and helper functions for the video frame deframer.
// No dependencies; every other file in rtl imports this package.
package vfd_pkg;

    // Inserted block length and frame size field width
    localparam int STRIP_BLOCK_BYTES = 20;
    localparam int SIZE_BITS         = 20;

    // Skip counter holds the bytes left in a block after its 4-byte signature
    localparam int SKIP_W = $clog2(STRIP_BLOCK_BYTES - 3);
    localparam logic [SKIP_W-1:0] SKIP_LOAD = SKIP_W'(STRIP_BLOCK_BYTES - 4);

    // Queue between the strip front and the parser back
    localparam int QUEUE_DEPTH = 16;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Configuration port
    localparam int MAX_W       = 20;
    localparam int MIN_W       = 8;
    localparam int CFG_DATA_W  = 20;
    localparam int CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_FRAME = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_MIN_FRAME = 1'b1;
    localparam logic [MAX_W-1:0] MAX_RESET = MAX_W'(300 * 1024);
    localparam logic [MIN_W-1:0] MIN_RESET = MIN_W'(10);

    // Header layout
    localparam int LEN_W = 32;
    localparam logic [3:0] FC_LAST_IDX = 4'd15;
    localparam logic [3:0] FD_LAST_IDX = 4'd7;
    localparam logic [3:0] HDR_SYNC_BYTES = 4'd4;
    localparam logic [LEN_W:0] FC_HDR_BYTES = (LEN_W+1)'(16);
    localparam logic [LEN_W:0] FD_HDR_BYTES = (LEN_W+1)'(8);
    localparam logic [LEN_W:0] SIZE_LIMIT = (LEN_W+1)'((64'd1 << SIZE_BITS) - 64'd1);

    // Byte codes
    localparam logic [7:0] BYTE_00   = 8'h00;
    localparam logic [7:0] BYTE_01   = 8'h01;
    localparam logic [7:0] BYTE_FF   = 8'hFF;
    localparam logic [7:0] SYNC_FC   = 8'hFC;
    localparam logic [7:0] SYNC_FD   = 8'hFD;

    // Released bytes of one input word: held signature prefix plus optional byte
    typedef struct packed {
        logic [1:0] pre;
        logic       has_byte;
        logic [7:0] data;
    } vfd_entry_t;

    // Parser to output stage: one result and/or end of the current input's run
    typedef struct packed {
        logic       res_valid;
        logic       close;
        logic [7:0] data;
        logic       first;
        logic       last;
        logic       kind;
    } vfd_event_t;

    // Inserted block signature FF 01 00 00
    function automatic logic [7:0] strip_sig(input logic [1:0] idx);
        logic [7:0] b;
        unique case (idx) inside
            2'd0:       b = BYTE_FF;
            2'd1:       b = BYTE_01;
            2'd2, 2'd3: b = BYTE_00;
        endcase
        return b;
    endfunction

    // Header sync bytes 00 00 01 FC/FD
    function automatic logic [7:0] hdr_sync(input logic [1:0] idx, input logic kind);
        logic [7:0] b;
        unique case (idx) inside
            2'd0, 2'd1: b = BYTE_00;
            2'd2:       b = BYTE_01;
            2'd3:       b = kind ? SYNC_FD : SYNC_FC;
        endcase
        return b;
    endfunction

endpackage

/* rtl/video_frame_deframer.sv */
// Video frame deframer top level: strip front, entry queue, parser back and
// output stage. Uses vfd_pkg, vfd_strip, vfd_fifo, vfd_parse and vfd_out.
// A payload byte passes the entry queue, the hold register and the output register.
// Throughput: one input byte per cycle; each released byte takes one parser step,
// and a completed header replays 8 or 16 bytes at one per cycle while the output
// is not stalled, so a header burst stalls input only once the 16-entry queue fills.
// Reset: rst_n clears all control state at once; the size registers return to
// 307200 and 10; header storage holds no reset value.
module video_frame_deframer import vfd_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [7:0]             data_byte,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [7:0]             out_byte,
    output logic                   frame_first,
    output logic                   frame_last,
    output logic                   header_kind,
    output logic                   run_last,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    logic       push;
    vfd_entry_t push_entry;
    vfd_entry_t head;
    logic       head_valid;
    logic       q_full;
    logic       pop;
    logic       step;
    vfd_event_t ev;

    vfd_strip u_strip (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .data_byte (data_byte),
        .q_full    (q_full),
        .push      (push),
        .entry     (push_entry)
    );

    vfd_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .head_valid (head_valid),
        .full       (q_full)
    );

    vfd_parse u_parse (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .head       (head),
        .head_valid (head_valid),
        .step       (step),
        .pop        (pop),
        .ev         (ev)
    );

    vfd_out u_out (
        .clk         (clk),
        .rst_n       (rst_n),
        .ev          (ev),
        .step        (step),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_byte    (out_byte),
        .frame_first (frame_first),
        .frame_last  (frame_last),
        .header_kind (header_kind),
        .run_last    (run_last)
    );

endmodule

/* rtl/vfd_strip.sv */
// Front part: removes inserted blocks that begin FF 01 00 00 and packs the
// bytes released by each input word into one queue entry. Uses vfd_pkg.
module vfd_strip import vfd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] data_byte,
    input  logic       q_full,
    output logic       push,
    output vfd_entry_t entry
);

    logic [1:0]        match_reg;
    logic [1:0]        match_next;
    logic [SKIP_W-1:0] skip_reg;
    logic [SKIP_W-1:0] skip_next;
    logic              accept;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;

    // Classify the word: skip, extend the signature, or release held bytes
    always_comb
    begin
        match_next     = match_reg;
        skip_next      = skip_reg;
        entry.pre      = 2'd0;
        entry.has_byte = 1'b0;
        entry.data     = data_byte;
        if (skip_reg != '0)
        begin
            skip_next = skip_reg - SKIP_W'(1);
        end
        else if (data_byte == strip_sig(match_reg))
        begin
            if (match_reg == 2'd3)
            begin
                match_next = 2'd0;
                skip_next  = SKIP_LOAD;
            end
            else
            begin
                match_next = match_reg + 2'd1;
            end
        end
        else
        begin
            entry.pre  = match_reg;
            match_next = 2'd0;
            if (data_byte == BYTE_FF)
                match_next = 2'd1;
            else
                entry.has_byte = 1'b1;
        end
    end

    assign push = accept && ((entry.pre != 2'd0) || entry.has_byte);

    // Advance strip state on each accepted word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg <= 2'd0;
            skip_reg  <= '0;
        end
        else if (accept)
        begin
            match_reg <= match_next;
            skip_reg  <= skip_next;
        end
    end

endmodule

/* rtl/vfd_fifo.sv */
// Short queue of released-byte entries between the strip front and the parser.
// Uses vfd_pkg for the entry type and depth.
module vfd_fifo import vfd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  vfd_entry_t push_entry,
    input  logic       pop,
    output vfd_entry_t head,
    output logic       head_valid,
    output logic       full
);

    vfd_entry_t        mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    assign head       = mem_reg[rd_ptr_reg];
    assign head_valid = (count_reg != '0);
    assign full       = (count_reg == QCNT_W'(QUEUE_DEPTH));

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + QCNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - QCNT_W'(1);
    end

    // Store entries
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_entry;
    end

    // Move pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            count_reg <= count_next;
        end
    end

endmodule

/* rtl/vfd_parse.sv */
// Back part: hunts for frame headers, checks the size, replays the header and
// passes the payload, one byte per step. Holds the size registers. Uses vfd_pkg.
module vfd_parse import vfd_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  vfd_entry_t             head,
    input  logic                   head_valid,
    input  logic                   step,
    output logic                   pop,
    output vfd_event_t             ev
);

    typedef enum logic [1:0] {MODE_HUNT, MODE_HEADER, MODE_PAYLOAD, MODE_EMIT} mode_t;

    mode_t                mode_reg;
    mode_t                mode_next;
    logic [1:0]           hunt_reg;
    logic [1:0]           hunt_next;
    logic [3:0]           count_reg;
    logic [3:0]           count_next;
    logic                 type_reg;
    logic                 type_next;
    logic [LEN_W-1:0]     len_reg;
    logic [LEN_W-1:0]     len_next;
    logic [SIZE_BITS-1:0] left_reg;
    logic [SIZE_BITS-1:0] left_next;
    logic [1:0]           sub_reg;
    logic [1:0]           sub_next;
    logic [3:0]           emit_idx_reg;
    logic [3:0]           emit_idx_next;
    logic                 zero_pay_reg;
    logic                 zero_pay_next;
    logic [MAX_W-1:0]     max_reg;
    logic [MIN_W-1:0]     min_reg;
    logic [7:0]           store_reg [16];

    logic                 store_we;
    logic                 advance;
    logic [7:0]           cur;
    logic [2:0]           last_sub;
    logic                 sub_last;
    logic [3:0]           need_last;
    logic [LEN_W-1:0]     len_shift;
    logic [LEN_W:0]       total;
    logic                 bad_size;

    // Current sub-byte of the head entry
    assign cur       = (sub_reg < head.pre) ? strip_sig(sub_reg) : head.data;
    assign last_sub  = {1'b0, head.pre} + {2'b00, head.has_byte} - 3'd1;
    assign sub_last  = ({1'b0, sub_reg} == last_sub);
    assign need_last = type_reg ? FD_LAST_IDX : FC_LAST_IDX;

    // Length field shifts in from the top; the last four header bytes remain
    assign len_shift = {cur, len_reg[LEN_W-1:8]};
    assign total     = {1'b0, len_shift} + (type_reg ? FD_HDR_BYTES : FC_HDR_BYTES);
    assign bad_size  = (total <= (LEN_W+1)'(min_reg)) || (total > (LEN_W+1)'(max_reg))
                    || (total > SIZE_LIMIT);

    always_comb
    begin
        mode_next     = mode_reg;
        hunt_next     = hunt_reg;
        count_next    = count_reg;
        type_next     = type_reg;
        len_next      = len_reg;
        left_next     = left_reg;
        sub_next      = sub_reg;
        emit_idx_next = emit_idx_reg;
        zero_pay_next = zero_pay_reg;
        store_we      = 1'b0;
        advance       = 1'b0;
        pop           = 1'b0;
        ev            = '0;
        ev.kind       = type_reg;
        ev.data       = cur;
        if (step)
        begin
            unique case (mode_reg)
                MODE_EMIT:
                begin
                    // Replay the stored header, sync bytes from constants
                    ev.res_valid = 1'b1;
                    ev.data      = (emit_idx_reg < HDR_SYNC_BYTES)
                                 ? hdr_sync(emit_idx_reg[1:0], type_reg)
                                 : store_reg[emit_idx_reg];
                    ev.first     = (emit_idx_reg == 4'd0);
                    ev.last      = (emit_idx_reg == need_last) && zero_pay_reg;
                    if (emit_idx_reg == need_last)
                    begin
                        ev.close  = sub_last;
                        advance   = 1'b1;
                        mode_next = zero_pay_reg ? MODE_HUNT : MODE_PAYLOAD;
                    end
                    else
                    begin
                        emit_idx_next = emit_idx_reg + 4'd1;
                    end
                end
                MODE_PAYLOAD:
                begin
                    if (head_valid)
                    begin
                        ev.res_valid = 1'b1;
                        ev.last      = (left_reg <= SIZE_BITS'(1));
                        ev.close     = sub_last;
                        advance      = 1'b1;
                        if (left_reg <= SIZE_BITS'(1))
                        begin
                            left_next = '0;
                            hunt_next = 2'd0;
                            mode_next = MODE_HUNT;
                        end
                        else
                        begin
                            left_next = left_reg - SIZE_BITS'(1);
                        end
                    end
                end
                MODE_HEADER:
                begin
                    if (head_valid)
                    begin
                        store_we   = 1'b1;
                        len_next   = len_shift;
                        count_next = count_reg + 4'd1;
                        if (count_reg == need_last)
                        begin
                            hunt_next = 2'd0;
                            if (bad_size)
                            begin
                                // Drop the header and resume hunting
                                mode_next = MODE_HUNT;
                                advance   = 1'b1;
                                ev.close  = sub_last;
                            end
                            else
                            begin
                                mode_next     = MODE_EMIT;
                                emit_idx_next = 4'd0;
                                zero_pay_next = (len_shift == '0);
                                left_next     = len_shift[SIZE_BITS-1:0];
                            end
                        end
                        else
                        begin
                            advance  = 1'b1;
                            ev.close = sub_last;
                        end
                    end
                end
                MODE_HUNT:
                begin
                    if (head_valid)
                    begin
                        advance  = 1'b1;
                        ev.close = sub_last;
                        unique case (hunt_reg)
                            2'd0: hunt_next = (cur == BYTE_00) ? 2'd1 : 2'd0;
                            2'd1: hunt_next = (cur == BYTE_00) ? 2'd2 : 2'd0;
                            2'd2: hunt_next = (cur == BYTE_00) ? 2'd2
                                            : (cur == BYTE_01) ? 2'd3 : 2'd0;
                            2'd3:
                            begin
                                if (cur == SYNC_FC || cur == SYNC_FD)
                                begin
                                    type_next  = (cur == SYNC_FD);
                                    count_next = HDR_SYNC_BYTES;
                                    hunt_next  = 2'd0;
                                    mode_next  = MODE_HEADER;
                                end
                                else
                                begin
                                    hunt_next = (cur == BYTE_00) ? 2'd1 : 2'd0;
                                end
                            end
                        endcase
                    end
                end
            endcase
            // Step to the next sub-byte, release the entry after its last one
            if (advance)
            begin
                if (sub_last)
                begin
                    pop      = 1'b1;
                    sub_next = 2'd0;
                end
                else
                begin
                    sub_next = sub_reg + 2'd1;
                end
            end
        end
    end

    // Store header bytes past the sync word
    always_ff @(posedge clk)
    begin
        if (store_we)
            store_reg[count_reg] <= cur;
    end

    // Hold parser state and size registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_HUNT;
            hunt_reg     <= 2'd0;
            count_reg    <= 4'd0;
            type_reg     <= 1'b0;
            len_reg      <= '0;
            left_reg     <= '0;
            sub_reg      <= 2'd0;
            emit_idx_reg <= 4'd0;
            zero_pay_reg <= 1'b0;
            max_reg      <= MAX_RESET;
            min_reg      <= MIN_RESET;
        end
        else
        begin
            mode_reg     <= mode_next;
            hunt_reg     <= hunt_next;
            count_reg    <= count_next;
            type_reg     <= type_next;
            len_reg      <= len_next;
            left_reg     <= left_next;
            sub_reg      <= sub_next;
            emit_idx_reg <= emit_idx_next;
            zero_pay_reg <= zero_pay_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_MAX_FRAME: max_reg <= cfg_data[MAX_W-1:0];
                    REG_MIN_FRAME: min_reg <= cfg_data[MIN_W-1:0];
                endcase
            end
        end
    end

endmodule

/* rtl/vfd_out.sv */
// Output stage: holds the newest result until its run is known to go on or end,
// then marks run_last and drives the output register. Uses vfd_pkg.
module vfd_out import vfd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  vfd_event_t ev,
    output logic       step,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       frame_first,
    output logic       frame_last,
    output logic       header_kind,
    output logic       run_last
);

    logic       hold_valid_reg;
    logic       hold_closed_reg;
    logic [7:0] hold_byte_reg;
    logic       hold_first_reg;
    logic       hold_last_reg;
    logic       hold_kind_reg;
    logic       out_valid_reg;
    logic [7:0] out_byte_reg;
    logic       out_first_reg;
    logic       out_last_reg;
    logic       out_kind_reg;
    logic       out_run_last_reg;

    logic       out_free;
    logic       close_hold;
    logic       move_hold;

    assign out_free   = !out_valid_reg || !out_stall;
    assign step       = !hold_valid_reg || out_free;
    assign close_hold = ev.close && !ev.res_valid && hold_valid_reg && !hold_closed_reg;
    assign move_hold  = hold_valid_reg && out_free
                     && (hold_closed_reg || ev.res_valid || close_hold);

    assign out_valid   = out_valid_reg;
    assign out_byte    = out_byte_reg;
    assign frame_first = out_first_reg;
    assign frame_last  = out_last_reg;
    assign header_kind = out_kind_reg;
    assign run_last    = out_run_last_reg;

    // Hold the newest result; advance the held one to the output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg  <= 1'b0;
            hold_closed_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (ev.res_valid)
            begin
                hold_valid_reg  <= 1'b1;
                hold_closed_reg <= ev.close;
            end
            else if (move_hold)
            begin
                hold_valid_reg  <= 1'b0;
                hold_closed_reg <= 1'b0;
            end
            else if (close_hold)
            begin
                hold_closed_reg <= 1'b1;
            end

            if (move_hold)
                out_valid_reg <= 1'b1;
            else if (out_free)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (ev.res_valid)
        begin
            hold_byte_reg  <= ev.data;
            hold_first_reg <= ev.first;
            hold_last_reg  <= ev.last;
            hold_kind_reg  <= ev.kind;
        end
        if (move_hold)
        begin
            out_byte_reg     <= hold_byte_reg;
            out_first_reg    <= hold_first_reg;
            out_last_reg     <= hold_last_reg;
            out_kind_reg     <= hold_kind_reg;
            out_run_last_reg <= hold_closed_reg || close_hold;
        end
    end

endmodule

/* rtl/vfd_checker.sv */
// Port-level checks for the video frame deframer, bound to the top level.
// Uses vfd_pkg for the configuration port widths.
module vfd_checker import vfd_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   in_valid,
    input logic                   in_stall,
    input logic [7:0]             data_byte,
    input logic                   out_valid,
    input logic                   out_stall,
    input logic [7:0]             out_byte,
    input logic                   frame_first,
    input logic                   frame_last,
    input logic                   header_kind,
    input logic                   run_last,
    input logic                   cfg_we,
    input logic [CFG_INDEX_W-1:0] cfg_index,
    input logic [CFG_DATA_W-1:0]  cfg_data
);

    logic in_frame_reg;
    logic kind_reg;
    logic out_acc;

    assign out_acc = out_valid && !out_stall;

    // Track frame boundaries from accepted output words
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg <= 1'b0;
            kind_reg     <= 1'b0;
        end
        else if (out_acc)
        begin
            in_frame_reg <= !frame_last;
            if (frame_first)
                kind_reg <= header_kind;
        end
    end

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(frame_first)
            && $stable(frame_last) && $stable(run_last))
        else $error("output word changed while stalled");

    a_first_opens: assert property (@(posedge clk) disable iff (!rst_n)
        out_acc && frame_first |-> !in_frame_reg)
        else $error("frame started before previous frame ended");

    a_inside_frame: assert property (@(posedge clk) disable iff (!rst_n)
        out_acc && !frame_first |-> in_frame_reg && (header_kind == kind_reg))
        else $error("frame word outside a frame or header kind changed");

    a_first_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(frame_first && frame_last))
        else $error("frame shorter than its header");

endmodule

bind video_frame_deframer vfd_checker u_vfd_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .data_byte   (data_byte),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_byte    (out_byte),
    .frame_first (frame_first),
    .frame_last  (frame_last),
    .header_kind (header_kind),
    .run_last    (run_last),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
);

/* tb/sv/tb_video_frame_deframer.sv */
`timescale 1ns / 100ps
// Self-checking bench for video_frame_deframer: byte stream in, frame words out.
// Depends on vfd_pkg and the deframer RTL; checks every word against a built-in predictor.
module tb_video_frame_deframer;
    import vfd_pkg::*;

    localparam int SETTLE_CYCLES   = 40;
    localparam int LONG_HOLD       = 300;
    localparam int PHASE_BYTES     = 105;
    localparam int MAX_REPORTS     = 40;
    localparam logic [31:0] STRIP_SIGNATURE = {BYTE_FF, BYTE_01, BYTE_00, BYTE_00};
    localparam logic [32:0] FRAME_SIZE_CAP  = 33'((64'd1 << SIZE_BITS) - 64'd1);

    typedef enum logic [1:0] {PARSE_HUNT, PARSE_HEADER, PARSE_PAYLOAD} parse_state_e;

    typedef struct packed {
        logic [7:0] data;
        logic       is_first;
        logic       is_last;
        logic       fd_kind;
        logic       run_end;
    } frame_word_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    logic [7:0]             data_byte = 8'h00;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic [7:0]             out_byte;
    logic                   frame_first;
    logic                   frame_last;
    logic                   header_kind;
    logic                   run_last;
    logic                   cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = REG_MAX_FRAME;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    // Predictor state
    logic [MAX_W-1:0]     size_max = MAX_RESET;
    logic [MIN_W-1:0]     size_min = MIN_RESET;
    logic [7:0]           strip_held [3];
    logic [1:0]           strip_depth = 2'd0;
    logic [4:0]           skip_count = 5'd0;
    logic [1:0]           sync_depth = 2'd0;
    logic [7:0]           hdr_bytes [16];
    logic [4:0]           hdr_fill = 5'd0;
    logic                 hdr_is_fd = 1'b0;
    logic [SIZE_BITS-1:0] payload_left = '0;
    parse_state_e         parse_state = PARSE_HUNT;

    frame_word_t expected_words [$];
    logic [7:0]  pending_bytes [$];
    int          mismatch_count = 0;
    int          bytes_accepted = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          stall_hold_cycles = 0;

    video_frame_deframer dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .data_byte   (data_byte),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_byte    (out_byte),
        .frame_first (frame_first),
        .frame_last  (frame_last),
        .header_kind (header_kind),
        .run_last    (run_last),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ---------------------------------------------------------------- predictor

    function automatic void emit_word(input logic [7:0] data, input logic is_first,
                                      input logic is_last);
        frame_word_t w;
        w.data     = data;
        w.is_first = is_first;
        w.is_last  = is_last;
        w.fd_kind  = hdr_is_fd;
        w.run_end  = 1'b0;
        expected_words.push_back(w);
    endfunction

    function automatic void restart_hunt();
        parse_state = PARSE_HUNT;
        sync_depth  = 2'd0;
        hdr_fill    = 5'd0;
    endfunction

    // Check the length field and replay the header if the size is in bounds
    function automatic void close_header();
        int          need;
        logic [31:0] hdr_len;
        logic [32:0] frame_total;
        need        = hdr_is_fd ? 8 : 16;
        hdr_len     = {hdr_bytes[need-1], hdr_bytes[need-2], hdr_bytes[need-3],
                       hdr_bytes[need-4]};
        frame_total = {1'b0, hdr_len} + 33'(need);
        if (frame_total <= 33'(size_min) || frame_total > 33'(size_max) ||
            frame_total > FRAME_SIZE_CAP)
        begin
            restart_hunt();
            return;
        end
        for (int i = 0; i < need; i++)
            emit_word(hdr_bytes[i], i == 0, (i == need - 1) && (hdr_len == 0));
        hdr_fill   = 5'd0;
        sync_depth = 2'd0;
        if (hdr_len == 0)
            parse_state = PARSE_HUNT;
        else
        begin
            parse_state  = PARSE_PAYLOAD;
            payload_left = hdr_len[SIZE_BITS-1:0];
        end
    endfunction

    function automatic void parse_byte(input logic [7:0] b);
        case (parse_state)
            PARSE_PAYLOAD:
            begin
                emit_word(b, 1'b0, payload_left <= 1);
                if (payload_left <= 1)
                begin
                    payload_left = '0;
                    restart_hunt();
                end
                else
                    payload_left = payload_left - 1'b1;
            end
            PARSE_HEADER:
            begin
                hdr_bytes[hdr_fill[3:0]] = b;
                hdr_fill = hdr_fill + 5'd1;
                if (hdr_fill >= (hdr_is_fd ? 5'd8 : 5'd16))
                    close_header();
            end
            default:
            begin
                parse_state = PARSE_HUNT;
                case (sync_depth)
                    2'd0: sync_depth = (b == BYTE_00) ? 2'd1 : 2'd0;
                    2'd1: sync_depth = (b == BYTE_00) ? 2'd2 : 2'd0;
                    2'd2: sync_depth = (b == BYTE_00) ? 2'd2 : (b == BYTE_01) ? 2'd3 : 2'd0;
                    default:
                    begin
                        if (b == SYNC_FC || b == SYNC_FD)
                        begin
                            hdr_is_fd    = (b == SYNC_FD);
                            hdr_bytes[0] = BYTE_00;
                            hdr_bytes[1] = BYTE_00;
                            hdr_bytes[2] = BYTE_01;
                            hdr_bytes[3] = b;
                            hdr_fill     = 5'd4;
                            sync_depth   = 2'd0;
                            parse_state  = PARSE_HEADER;
                        end
                        else
                            sync_depth = (b == BYTE_00) ? 2'd1 : 2'd0;
                    end
                endcase
            end
        endcase
    endfunction

    // Strip inserted blocks, parse what is released, mark the end of the run
    function automatic void predict_byte(input logic [7:0] b);
        logic [7:0]  released [$];
        int          words_before;
        frame_word_t w;
        words_before = expected_words.size();
        if (skip_count != 0)
            skip_count = skip_count - 5'd1;
        else if (b == STRIP_SIGNATURE[8*(3-strip_depth) +: 8])
        begin
            if (strip_depth == 2'd3)
            begin
                strip_depth = 2'd0;
                skip_count  = 5'(STRIP_BLOCK_BYTES - 4);
            end
            else
            begin
                strip_held[strip_depth] = b;
                strip_depth = strip_depth + 2'd1;
            end
        end
        else
        begin
            for (int i = 0; i < strip_depth; i++)
                released.push_back(strip_held[i]);
            strip_depth = 2'd0;
            if (b == BYTE_FF)
            begin
                strip_held[0] = b;
                strip_depth   = 2'd1;
            end
            else
                released.push_back(b);
        end
        foreach (released[i])
            parse_byte(released[i]);
        if (expected_words.size() > words_before)
        begin
            w = expected_words.pop_back();
            w.run_end = 1'b1;
            expected_words.push_back(w);
        end
    endfunction

    // ---------------------------------------------------------------- stream builders

    function automatic void queue_strip_block();
        pending_bytes = {pending_bytes, BYTE_FF, BYTE_01, BYTE_00, BYTE_00};
        repeat (STRIP_BLOCK_BYTES - 4)
            pending_bytes.push_back(8'($urandom));
    endfunction

    // Queue a header with the given length field and random payload bytes;
    // cut places an inserted block ahead of that frame byte (negative: none)
    function automatic void queue_frame(input logic fd, input logic [31:0] len_field,
                                        input int payload_n, input int cut);
        logic [7:0] frame_bytes [$];
        frame_bytes = {BYTE_00, BYTE_00, BYTE_01, fd ? SYNC_FD : SYNC_FC};
        repeat (fd ? 0 : 8)
            frame_bytes.push_back(8'($urandom_range(254, 0)));
        for (int i = 0; i < 4; i++)
            frame_bytes.push_back(len_field[8*i +: 8]);
        repeat (payload_n)
            frame_bytes.push_back(8'($urandom));
        foreach (frame_bytes[i])
        begin
            if (i == cut)
                queue_strip_block();
            pending_bytes.push_back(frame_bytes[i]);
        end
    endfunction

    // Mostly good frames, then blocks, bad sizes, broken sequences and noise
    function automatic void queue_random_chunk();
        int   pick;
        int   need;
        int   lo;
        int   hi;
        int   pay;
        int   cut;
        logic fd;
        pick = $urandom_range(99);
        fd   = 1'($urandom);
        need = fd ? 8 : 16;
        lo   = int'(size_min) + 1 - need;
        if (lo < 0)
            lo = 0;
        hi = int'(size_max) - need;
        if (hi > 24)
            hi = 24;
        if (hi < lo)
            hi = lo;
        if (pick < 60)
        begin
            pay = $urandom_range(hi, lo);
            cut = ($urandom_range(4) == 0) ? int'($urandom_range(need + pay - 1)) : -1;
            queue_frame(fd, 32'(pay), pay, cut);
        end
        else if (pick < 68)
            queue_strip_block();
        else if (pick < 78)
        begin
            case ($urandom_range(2))
                0:
                begin
                    pay = int'(size_max) - need + 1 + int'($urandom_range(3));
                    if (pay < 0)
                        pay = 0;
                    queue_frame(fd, 32'(pay), 0, -1);
                end
                1: queue_frame(fd, 32'(lo > 0 ? $urandom_range(lo - 1) : 0), 0, -1);
                default: queue_frame(fd, $urandom() | 32'h0010_0000, 0, -1);
            endcase
        end
        else if (pick < 90)
        begin
            case ($urandom_range(4))
                0: pending_bytes = {pending_bytes, BYTE_FF, BYTE_01, BYTE_00,
                                    8'($urandom_range(254, 1))};
                1: pending_bytes = {pending_bytes, BYTE_FF, BYTE_01,
                                    8'($urandom_range(254, 1))};
                2: pending_bytes = {pending_bytes, BYTE_FF, BYTE_FF, BYTE_01, 8'h02};
                3: pending_bytes = {pending_bytes, BYTE_00, BYTE_00, BYTE_01,
                                    8'($urandom_range(8'hFB, 8'h02))};
                default: pending_bytes = {pending_bytes, BYTE_00, BYTE_00, BYTE_00, BYTE_00,
                                          BYTE_01, 8'hFE};
            endcase
        end
        else
            repeat ($urandom_range(6, 1))
                pending_bytes.push_back(8'($urandom));
    endfunction

    // ---------------------------------------------------------------- drivers

    // Offer one word, hold it until accepted, then predict its results
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= b;
        do
            @(posedge clk);
        while (in_stall);
        predict_byte(b);
        bytes_accepted++;
        @(negedge clk);
    endtask

    task automatic send_pending();
        while (pending_bytes.size() != 0)
            send_byte(pending_bytes.pop_front());
    endtask

    // Drop valid and wait until every expected word is out and the pipe is quiet
    task automatic wait_for_drain();
        in_valid <= 1'b0;
        @(negedge clk);
        while (expected_words.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES)
            @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_MAX_FRAME: size_max = value[MAX_W-1:0];
            REG_MIN_FRAME: size_min = value[MIN_W-1:0];
            default: ;
        endcase
        @(negedge clk);
    endtask

    task automatic set_limits(input logic [CFG_DATA_W-1:0] max_word,
                              input logic [CFG_DATA_W-1:0] min_word);
        wait_for_drain();
        write_reg(REG_MAX_FRAME, max_word);
        write_reg(REG_MIN_FRAME, min_word);
    endtask

    // Receiver: a requested hold-off first, otherwise random stalls
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (stall_hold_cycles > 0)
            begin
                out_stall <= 1'b1;
                stall_hold_cycles = stall_hold_cycles - 1;
            end
            else
                out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Compare every accepted output word with the oldest expectation
    always @(posedge clk)
    begin : check_words
        frame_word_t got;
        frame_word_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            got = '{out_byte, frame_first, frame_last, header_kind, run_last};
            if (expected_words.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("%0t: unexpected word byte=%h first=%b last=%b kind=%b run_last=%b",
                             $time, got.data, got.is_first, got.is_last, got.fd_kind,
                             got.run_end);
            end
            else
            begin
                want = expected_words.pop_front();
                if (got !== want)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display({"%0t: word mismatch expected byte=%h first=%b last=%b ",
                                  "kind=%b run_last=%b, actual byte=%h first=%b last=%b ",
                                  "kind=%b run_last=%b"},
                                 $time, want.data, want.is_first, want.is_last, want.fd_kind,
                                 want.run_end, got.data, got.is_first, got.is_last,
                                 got.fd_kind, got.run_end);
                end
            end
        end
    end

    // ---------------------------------------------------------------- tests

    task automatic test_directed_frames();
        // FC frame carrying the extreme byte values
        queue_frame(1'b0, 32'd4, 0, -1);
        pending_bytes = {pending_bytes, 8'h00, 8'hFF, 8'h7F, 8'h80};
        // FD frame with an inserted block cut into its header
        queue_frame(1'b1, 32'd3, 3, 5);
        // total at the lower bound drops, one above it passes
        queue_frame(1'b1, 32'd2, 0, -1);
        queue_frame(1'b1, 32'd3, 3, -1);
        // broken signature prefixes, one broken by a new FF
        pending_bytes = {pending_bytes, BYTE_FF, BYTE_01, BYTE_00, 8'h05,
                         BYTE_FF, BYTE_FF, BYTE_01, 8'h02};
        // prefix released ahead of a block; bytes joined by the removal stay unscanned
        pending_bytes = {pending_bytes, BYTE_FF, BYTE_01};
        queue_strip_block();
        pending_bytes = {pending_bytes, BYTE_00, BYTE_00, 8'h05};
        // length beyond the size field
        queue_frame(1'b0, 32'hFFFF_FFFF, 0, -1);
        // sync broken on its last byte
        pending_bytes = {pending_bytes, BYTE_00, BYTE_00, BYTE_01, 8'h7E};
        // back-to-back one-byte frames
        queue_frame(1'b1, 32'd1, 1, -1);
        queue_frame(1'b0, 32'd1, 1, -1);
        send_pending();
        wait_for_drain();
    endtask

    task automatic test_size_limits();
        // upper data bits fall away on the narrow register; empty payloads
        set_limits(MAX_RESET, 20'hABC00);
        queue_frame(1'b1, 32'd0, 0, -1);
        queue_frame(1'b0, 32'd0, 0, -1);
        send_pending();
        // upper bound below lower bound drops everything
        set_limits(20'd11, 20'd200);
        queue_frame(1'b1, 32'd0, 0, -1);
        queue_frame(1'b1, 32'd3, 3, -1);
        send_pending();
        // tightest upper bound
        set_limits(20'd11, 20'd0);
        queue_frame(1'b1, 32'd3, 3, -1);
        queue_frame(1'b1, 32'd4, 4, -1);
        queue_frame(1'b0, 32'd0, 0, -1);
        queue_frame(1'b1, 32'd0, 0, -1);
        send_pending();
        // widest upper bound, highest lower bound
        set_limits(20'hFFFFF, 20'd255);
        queue_frame(1'b0, 32'd240, 240, -1);
        queue_frame(1'b0, 32'd239, 239, -1);
        queue_frame(1'b1, 32'h000F_FFF8, 0, -1);
        send_pending();
        set_limits(MAX_RESET, MIN_RESET);
    endtask

    task automatic test_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        // hold the output off while frames keep coming, so the input backs up
        stall_hold_cycles = LONG_HOLD;
        repeat (8)
            queue_frame(1'($urandom), 32'd12, 12, -1);
        send_pending();
        // pause the sender until every word is out
        wait_for_drain();
        recv_stall_pct = 66;
        repeat (4)
            queue_frame(1'($urandom), 32'd6, 6, -1);
        send_pending();
        wait_for_drain();
        recv_stall_pct = 0;
    endtask

    task automatic test_random_traffic();
        int send_pct [4] = '{0, 66, 0, 7};
        int recv_pct [4] = '{0, 0, 66, 7};
        int max_set  [4] = '{2047, 64, 40, 511};
        int min_set  [4] = '{10, 0, 20, 12};
        int target;
        for (int p = 0; p < 4; p++)
        begin
            set_limits(max_set[p], min_set[p]);
            send_idle_pct  = send_pct[p];
            recv_stall_pct = recv_pct[p];
            target = bytes_accepted + PHASE_BYTES;
            while (bytes_accepted < target)
            begin
                queue_random_chunk();
                send_pending();
            end
        end
        send_idle_pct  = 0;
        recv_stall_pct = 0;
    endtask

    initial
    begin
        repeat (7)
            @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_directed_frames();
        test_size_limits();
        test_backpressure();
        test_random_traffic();
        wait_for_drain();
        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Watchdog
    initial
    begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

/* video_frame_deframer.f */
rtl/vfd_pkg.sv
rtl/vfd_strip.sv
rtl/vfd_fifo.sv
rtl/vfd_parse.sv
rtl/vfd_out.sv
rtl/video_frame_deframer.sv
rtl/vfd_checker.sv
tb/sv/tb_video_frame_deframer.sv
